FILE: src/position_marker_table_macros.svh
// Assertion macros used by the marker table back part (pmt_back).
`ifndef POSITION_MARKER_TABLE_MACROS_SVH
`define POSITION_MARKER_TABLE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PMT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/pmt_pkg.sv
`default_nettype none
package pmt_pkg;

    localparam int MarkerSlots  = 64;
    localparam int PositionBits = 32;
    localparam int SlotBits     = (MarkerSlots > 1) ? $clog2(MarkerSlots) : 1;
    localparam int UsedBits     = $clog2(MarkerSlots + 1);

    typedef logic [PositionBits-1:0] t_pos;
    typedef logic [SlotBits-1:0]     t_slot;
    typedef logic [UsedBits-1:0]     t_used;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_RESOLVE = 3'd1,
        CMD_SET_POS = 3'd2,
        CMD_SET_GRV = 3'd3,
        CMD_GET_GRV = 3'd4,
        CMD_DELETE  = 3'd5,
        CMD_RELOC   = 3'd6,
        CMD_DETACH  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_GONE     = 2'd1,
        ST_BAD_GRAV = 2'd2,
        ST_NO_SLOT  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] marker_id;
        logic [31:0] handle_generation;
        logic [31:0] new_position;
        logic [1:0]  gravity_in;
        logic [31:0] buffer_length;
        logic [31:0] edit_begin;
        logic [31:0] edit_end;
        logic [31:0] replacement_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle_id;
        logic [31:0] handle_gen;
        logic [31:0] position_out;
        logic        gravity_out;
    } t_out_item;

    // Classified work handed from the front part to the back part.
    typedef struct packed {
        t_cmd        cmd;
        logic        early;      // result already known, no table walk
        t_status     early_st;
        logic [31:0] id;
        logic [31:0] gen;
        t_pos        pos;        // clamped position
        logic        grav;
        t_pos        eb;
        t_pos        ee;
        t_pos        rl;
    } t_job;

    // Saturating add at the position width.
    function automatic t_pos sat_add(input t_pos a, input t_pos b);
        logic [PositionBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PositionBits] ? '1 : s[PositionBits-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/pmt_front.sv
`default_nettype none
module pmt_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  pmt_pkg::t_in_item      i_item,
    output logic                   o_busy,
    output logic                   o_job_valid,
    output pmt_pkg::t_job          o_job,
    input  wire logic              i_job_take
);
    import pmt_pkg::*;

    logic r_full;
    t_job r_job;
    t_job n_job;
    logic [31:0] clamped;

    // One-entry queue between the front and back parts.
    assign o_busy      = r_full;
    assign o_job_valid = r_full;
    assign o_job       = r_job;

    // Clamp the position and settle the invalid-gravity cases up front.
    always_comb begin
        clamped = (i_item.new_position > i_item.buffer_length) ?
                  i_item.buffer_length : i_item.new_position;
        n_job.cmd      = t_cmd'(i_item.command);
        n_job.id       = i_item.marker_id;
        n_job.gen      = i_item.handle_generation;
        n_job.pos      = t_pos'(clamped);
        n_job.grav     = i_item.gravity_in[0];
        n_job.eb       = t_pos'(i_item.edit_begin);
        n_job.ee       = t_pos'(i_item.edit_end);
        n_job.rl       = t_pos'(i_item.replacement_length);
        n_job.early    = 1'b0;
        n_job.early_st = ST_OK;
        if ((n_job.cmd == CMD_CREATE || n_job.cmd == CMD_SET_GRV) && i_item.gravity_in[1]) begin
            n_job.early    = 1'b1;
            n_job.early_st = ST_BAD_GRAV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_start && !r_full) begin
            r_full <= 1'b1;
        end else if (i_job_take) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_full) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

FILE: src/pmt_back.sv
`default_nettype none
`include "position_marker_table_macros.svh"
module pmt_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    input  pmt_pkg::t_job          i_job,
    output logic                   o_job_take,
    output logic                   o_done,
    output pmt_pkg::t_out_item     o_result
);
    import pmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_ACT, S_RELOC_W
    } t_state;

    // Slot storage: active bits and generation-written flags reset; the rest, gravity bits included, do not.
    logic [MarkerSlots-1:0] r_active;
    logic [31:0]            r_gen_mem [MarkerSlots];
    logic [MarkerSlots-1:0] r_gen_ok;       // generation written since reset
    logic [31:0]            r_id_mem  [MarkerSlots];
    t_pos                   r_pos_mem [MarkerSlots];
    logic [MarkerSlots-1:0] r_grav;

    t_state      r_state;
    t_job        r_job;
    t_slot       r_idx;
    t_used       r_used;
    logic [31:0] r_next_id;
    logic        r_found;
    logic        r_free_found;
    t_slot       r_hit;
    logic [31:0] r_rd_id;
    logic [31:0] r_rd_gen;
    t_pos        r_rd_pos;
    logic        r_done;
    t_out_item   r_result;

    logic [31:0] gen_cur;
    t_pos        reloc_pos;
    t_pos        old_len;
    logic        last;
    logic        idle_done;
    t_status     idle_st;

    assign o_done     = r_done;
    assign o_result   = r_result;
    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign last       = ({1'b0, r_idx} + 1'b1) >= r_used;

    // Registered reads of the slot memories at the walk index.
    always_ff @(posedge i_clk) begin
        r_rd_id  <= r_id_mem[r_idx];
        r_rd_gen <= r_gen_mem[r_idx];
        r_rd_pos <= r_pos_mem[r_idx];
    end

    assign gen_cur = r_gen_ok[r_idx] ? r_rd_gen : 32'd0;

    // Commands that finish at once without a table walk, and their status.
    always_comb begin
        idle_done = 1'b1;
        idle_st   = ST_OK;
        if (i_job.early) begin
            idle_st = i_job.early_st;
        end else if (i_job.cmd == CMD_CREATE && r_next_id == 32'hFFFF_FFFF) begin
            idle_st = ST_NO_SLOT;
        end else if (i_job.cmd != CMD_DETACH) begin
            if (r_used == '0) begin
                if (i_job.cmd == CMD_CREATE) begin
                    idle_done = 1'b0;
                end else if (i_job.cmd != CMD_RELOC) begin
                    idle_st = ST_GONE;
                end
            end else begin
                idle_done = 1'b0;
            end
        end
    end

    // Position update for one marker after an edit.
    always_comb begin
        old_len   = (r_job.ee > r_job.eb) ? r_job.ee - r_job.eb : '0;
        reloc_pos = r_rd_pos;
        if (old_len == '0) begin
            if (r_rd_pos > r_job.eb) begin
                reloc_pos = sat_add(r_rd_pos, r_job.rl);
            end else if (r_rd_pos == r_job.eb && r_grav[r_idx]) begin
                reloc_pos = sat_add(r_job.eb, r_job.rl);
            end
        end else if (r_rd_pos >= r_job.ee) begin
            if (r_job.rl >= old_len) begin
                reloc_pos = sat_add(r_rd_pos, r_job.rl - old_len);
            end else begin
                reloc_pos = r_rd_pos - (old_len - r_job.rl);
            end
        end else if (r_rd_pos >= r_job.eb) begin
            reloc_pos = r_grav[r_idx] ? sat_add(r_job.eb, r_job.rl) : r_job.eb;
        end
    end

    // Command sequencer: walk the used slots, each through S_READ and then S_SCAN or S_RELOC_W.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_gen_ok  <= '0;
            r_used    <= '0;
            r_next_id <= 32'd1;
            r_idx     <= '0;
            r_done    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job        <= i_job;
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_result     <= {idle_st, 97'd0};
                        r_done       <= idle_done;
                        if (i_job.cmd == CMD_DETACH) begin
                            r_active <= '0;
                        end
                        if (!idle_done) begin
                            r_state <= (r_used == '0) ? S_ACT : S_READ;
                        end
                    end else begin
                        r_done <= 1'b0;
                    end
                end
                S_READ: begin
                    // Memory read of r_idx is registered here for use in S_SCAN or S_RELOC_W.
                    r_done  <= 1'b0;
                    r_state <= (r_job.cmd == CMD_RELOC) ? S_RELOC_W : S_SCAN;
                end
                S_RELOC_W: begin
                    if (r_active[r_idx]) begin
                        r_pos_mem[r_idx] <= reloc_pos;
                    end
                    r_done <= last;
                    if (last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_SCAN: begin
                    r_done <= 1'b0;
                    if (r_job.cmd == CMD_CREATE) begin
                        if (!r_active[r_idx]) begin
                            r_free_found <= 1'b1;
                            r_hit        <= r_idx;
                            r_state      <= S_ACT;
                        end else if (last) begin
                            r_state <= S_ACT;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end else if (r_active[r_idx] && r_rd_id == r_job.id
                                 && gen_cur == r_job.gen) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx;
                        r_state <= S_ACT;
                    end else if (last) begin
                        r_state <= S_ACT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_ACT: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (r_job.cmd == CMD_CREATE) begin
                        if (!r_free_found && r_used >= t_used'(MarkerSlots)) begin
                            r_result <= {ST_NO_SLOT, 97'd0};
                        end else begin
                            // A reused slot's generation comes from the registered read;
                            // an appended slot was never written and starts at one.
                            logic [31:0] g;
                            t_slot       s;
                            s = r_free_found ? r_hit : t_slot'(r_used);
                            g = (r_free_found && r_gen_ok[s]) ? r_rd_gen + 32'd1 : 32'd1;
                            if (!r_free_found) begin
                                r_used <= r_used + 1'b1;
                            end
                            r_id_mem[s]  <= r_next_id;
                            r_gen_mem[s] <= g;
                            r_gen_ok[s]  <= 1'b1;
                            r_pos_mem[s] <= r_job.pos;
                            r_grav[s]    <= r_job.grav;
                            r_active[s]  <= 1'b1;
                            r_next_id    <= r_next_id + 32'd1;
                            r_result     <= {ST_OK, r_next_id, g, 32'd0, 1'b0};
                        end
                    end else if (!r_found) begin
                        r_result <= {ST_GONE, 97'd0};
                    end else begin
                        r_result <= {ST_OK, 64'd0,
                                     (r_job.cmd == CMD_RESOLVE) ? 32'(r_rd_pos) : 32'd0,
                                     (r_job.cmd == CMD_GET_GRV) && r_grav[r_hit]};
                        case (r_job.cmd)
                            CMD_SET_POS: r_pos_mem[r_hit] <= r_job.pos;
                            CMD_SET_GRV: r_grav[r_hit] <= r_job.grav;
                            CMD_DELETE:  r_active[r_hit] <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PMT_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= t_used'(MarkerSlots))
    `PMT_ASSERT_NEXT(a_take_idle, i_clk, i_rst_n, o_job_take && !idle_done && r_used != '0, r_state == S_READ)
    `PMT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)

endmodule
`default_nettype wire

FILE: src/position_marker_table.sv
// Channel   Direction  Handshake               Payload
// command   in         i_start / o_busy        i_item  (pmt_pkg::t_in_item)
// result    out        o_done strobe           o_result (pmt_pkg::t_out_item)
//
// One command at a time in the back part; the front holds one more beat while it works.
// Early-fail, detach-all and empty-table commands finish without a table walk (a
// create on an empty table still passes its action state); lookups, creates and
// relocates walk the used slots, each slot taking a memory read and then a compare
// or write. Reset is synchronous, active low; the result strobe lasts one cycle
// and cannot be stalled.
`default_nettype none
module position_marker_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  pmt_pkg::t_in_item      i_item,
    output logic                   o_busy,
    output logic                   o_done,
    output pmt_pkg::t_out_item     o_result
);
    import pmt_pkg::*;

    logic job_valid;
    logic job_take;
    t_job job;

    // Front part: accept and classify a beat.
    pmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_item     (i_item),
        .o_busy     (o_busy),
        .o_job_valid(job_valid),
        .o_job      (job),
        .i_job_take (job_take)
    );

    // Back part: walk the table and return the result.
    pmt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(job_valid),
        .i_job      (job),
        .o_job_take (job_take),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire
